[src/sclc_pkg.sv]
// Shared types, codes and widths of the soft cursor lock controller.
package sclc_pkg;

  localparam int COORD_W     = 16;
  localparam int SIZE_W      = 8;
  localparam int LOCK_EXT_W  = 17;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    OP_SHAPE  = 2'd0,
    OP_MOVE   = 2'd1,
    OP_LOCK   = 2'd2,
    OP_UNLOCK = 2'd3
  } opcode_t;

  typedef enum logic {
    ACT_RESTORE = 1'b0,
    ACT_DRAW    = 1'b1
  } action_t;

  // Back-end sequencer: first step of a command, then an optional second step.
  typedef enum logic {
    SEQ_FIRST,
    SEQ_SECOND
  } seq_state_t;

  // What the second step of a command does.
  typedef enum logic {
    SEC_DRAW,
    SEC_CHECK
  } second_t;

  // One classified command as it sits in the queue.
  typedef struct packed {
    opcode_t             op;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [COORD_W-1:0]  lw;
    logic [COORD_W-1:0]  lh;
    logic [SIZE_W-1:0]   hx;
    logic [SIZE_W-1:0]   hy;
    logic [SIZE_W-1:0]   sw;
    logic [SIZE_W-1:0]   sh;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] frame_width;
    logic [COORD_W-1:0] frame_height;
  } frame_cfg_t;

  typedef struct packed {
    action_t            action;
    logic [COORD_W-1:0] area_x;
    logic [COORD_W-1:0] area_y;
    logic [SIZE_W-1:0]  area_w;
    logic [SIZE_W-1:0]  area_h;
    logic               on_screen;
    logic               last;
  } result_t;

endpackage

[src/soft_cursor_lock_controller_top.sv]
// Top level of the soft cursor lock controller: ports, configuration and wiring.
//
// Commands enter on the s_ stream and land in a QUEUE_DEPTH-entry queue, one per
// cycle while the queue has room, so input accepts while results wait on the m_
// stream. The back end takes one command from the queue per step: a command that
// yields at most one action and needs no follow-up takes one step, while a shape
// change with a nonzero size, a move that redraws, and a lock while a cursor is
// present (set or merge, then overlap check) take a second step as well; the pace
// is set by the back-end sequencer and its single result register. Each action
// occupies the result register until the m_ stream takes it.
// Frame size registers are written on the cfg channel, which is always ready; there
// is no clearing pass after reset.
module soft_cursor_lock_controller_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // Command stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  // pos_x[15:0], pos_y[31:16], lock_w[47:32], lock_h[63:48],
  // hot_x[71:64], hot_y[79:72], shape_w[87:80], shape_h[95:88]
  input  logic [95:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  // Action stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  // area_x[15:0], area_y[31:16], area_w[39:32], area_h[47:40], on_screen[48],
  // zero fill[55:49]
  output logic [55:0] m_tdata,
  // action[0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sclc_pkg::*;

  frame_cfg_t frame;
  cmd_t       push_cmd;
  cmd_t       head;
  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  result_t    result;

  assign cfg_ready = 1'b1;

  // Frame size registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame.frame_width  <= 16'd1024;
      frame.frame_height <= 16'd768;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame.frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame.frame_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sclc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .frame    (frame),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  sclc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  sclc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .frame   (frame),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .result  (result)
  );

  // Pack the result transaction.
  assign m_tdata = {7'd0, result.on_screen, result.area_h, result.area_w,
                    result.area_y, result.area_x};
  assign m_tuser = result.action;
  assign m_tlast = result.last;

endmodule

[src/sclc_front.sv]
// Front end: takes command transactions, decodes them and clamps move targets.
module sclc_front (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [95:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  sclc_pkg::frame_cfg_t frame,
  input  logic                 full,
  output logic                 push,
  output sclc_pkg::cmd_t       push_cmd
);
  import sclc_pkg::*;

  logic [COORD_W-1:0] raw_x;
  logic [COORD_W-1:0] raw_y;
  logic [COORD_W-1:0] max_x;
  logic [COORD_W-1:0] max_y;
  opcode_t            op;

  assign raw_x = s_tdata[15:0];
  assign raw_y = s_tdata[31:16];
  assign op    = opcode_t'(s_tuser);

  // Largest legal position; a zero frame size clamps to zero.
  assign max_x = (frame.frame_width  != '0) ? frame.frame_width  - 16'd1 : '0;
  assign max_y = (frame.frame_height != '0) ? frame.frame_height - 16'd1 : '0;

  // Build the queue entry; only a move clamps its position.
  always_comb begin
    push_cmd    = '0;
    push_cmd.op = op;
    push_cmd.px = raw_x;
    push_cmd.py = raw_y;
    push_cmd.lw = s_tdata[47:32];
    push_cmd.lh = s_tdata[63:48];
    push_cmd.hx = s_tdata[71:64];
    push_cmd.hy = s_tdata[79:72];
    push_cmd.sw = s_tdata[87:80];
    push_cmd.sh = s_tdata[95:88];
    if (op == OP_MOVE) begin
      if (raw_x >= frame.frame_width)  push_cmd.px = max_x;
      if (raw_y >= frame.frame_height) push_cmd.py = max_y;
    end
  end

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

endmodule

[src/sclc_queue.sv]
// Small command queue between the front end and the back end.
module sclc_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sclc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output sclc_pkg::cmd_t head,
  output logic           empty
);
  import sclc_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + IDX_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + IDX_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // The fill count never runs past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

  // The back end never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue popped while empty");

endmodule

[src/sclc_back.sv]
// Back end: cursor and lock state, action sequencing, clipping and result register.
module sclc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  sclc_pkg::frame_cfg_t frame,
  input  sclc_pkg::cmd_t       head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 m_valid,
  input  logic                 m_ready,
  output sclc_pkg::result_t    result
);
  import sclc_pkg::*;

  // True when the cursor rectangle overlaps the lock rectangle.
  function automatic logic locked_hit(
    input logic [15:0] cx, input logic [15:0] cy,
    input logic [7:0]  hx, input logic [7:0]  hy,
    input logic [7:0]  w,  input logic [7:0]  h,
    input logic [15:0] ll, input logic [15:0] lt,
    input logic [16:0] lw, input logic [16:0] lh
  );
    logic signed [18:0] x0, y0, xr, yb, lr, lb;
    x0 = $signed({3'b000, cx}) - $signed({11'd0, hx});
    y0 = $signed({3'b000, cy}) - $signed({11'd0, hy});
    xr = x0 + $signed({11'd0, w});
    yb = y0 + $signed({11'd0, h});
    lr = $signed({3'b000, ll}) + $signed({2'b00, lw});
    lb = $signed({3'b000, lt}) + $signed({2'b00, lh});
    return ($signed({3'b000, ll}) < xr) && ($signed({3'b000, lt}) < yb) &&
           (lr > x0) && (lb > y0);
  endfunction

  // Cursor and lock state.
  logic                  cursor_present, cursor_present_next;
  logic                  cursor_hidden,  cursor_hidden_next;
  logic                  lock_active,    lock_active_next;
  logic [COORD_W-1:0]    cursor_x,       cursor_x_next;
  logic [COORD_W-1:0]    cursor_y,       cursor_y_next;
  logic [SIZE_W-1:0]     hotspot_x,      hotspot_x_next;
  logic [SIZE_W-1:0]     hotspot_y,      hotspot_y_next;
  logic [SIZE_W-1:0]     cursor_w,       cursor_w_next;
  logic [SIZE_W-1:0]     cursor_h,       cursor_h_next;
  logic [COORD_W-1:0]    lock_left,      lock_left_next;
  logic [COORD_W-1:0]    lock_top,       lock_top_next;
  logic [LOCK_EXT_W-1:0] lock_width,     lock_width_next;
  logic [LOCK_EXT_W-1:0] lock_height,    lock_height_next;
  seq_state_t            seq_state,      seq_state_next;
  second_t               second,         second_next;

  logic    advance;
  logic    emit;
  action_t emit_action;
  logic    emit_last;
  logic    shape_nonzero;
  logic    locked_new;
  logic    locked_cur;
  logic    draw_follow;

  // Lock merge terms.
  logic [COORD_W-1:0]  merge_l, merge_t;
  logic [16:0]         new_r, new_b;
  logic [17:0]         old_r, old_b, ext_w, ext_h;

  // Clipping terms for the current cursor rectangle.
  logic signed [18:0] x0, y0, xr, yb, clip_l, clip_r, clip_t, clip_b, fw_s, fh_s;
  logic signed [18:0] span_w, span_h;
  logic               clip_on;

  assign advance = !m_valid || m_ready;

  // Clip the cursor rectangle to the frame buffer.
  always_comb begin
    fw_s    = $signed({3'b000, frame.frame_width});
    fh_s    = $signed({3'b000, frame.frame_height});
    x0      = $signed({3'b000, cursor_x}) - $signed({11'd0, hotspot_x});
    y0      = $signed({3'b000, cursor_y}) - $signed({11'd0, hotspot_y});
    xr      = x0 + $signed({11'd0, cursor_w});
    yb      = y0 + $signed({11'd0, cursor_h});
    clip_l  = (x0 < 0) ? 19'sd0 : x0;
    clip_t  = (y0 < 0) ? 19'sd0 : y0;
    clip_r  = (xr < fw_s) ? xr : fw_s;
    clip_b  = (yb < fh_s) ? yb : fh_s;
    clip_on = (clip_r > clip_l) && (clip_b > clip_t);
    span_w  = clip_r - clip_l;
    span_h  = clip_b - clip_t;
  end

  // Overlap tests: with the move target, and with the stored state.
  assign locked_new = locked_hit(head.px, head.py, hotspot_x, hotspot_y, cursor_w, cursor_h,
                                 lock_left, lock_top, lock_width, lock_height);
  assign locked_cur = locked_hit(cursor_x, cursor_y, hotspot_x, hotspot_y, cursor_w, cursor_h,
                                 lock_left, lock_top, lock_width, lock_height);

  assign shape_nonzero = (head.sw != '0) && (head.sh != '0);
  assign draw_follow   = cursor_present && !(lock_active && locked_new);

  // Bounding box of the stored lock and the new rectangle.
  always_comb begin
    merge_l = (head.px < lock_left) ? head.px : lock_left;
    merge_t = (head.py < lock_top)  ? head.py : lock_top;
    new_r   = {1'b0, head.px} + {1'b0, head.lw};
    new_b   = {1'b0, head.py} + {1'b0, head.lh};
    old_r   = {2'b00, lock_left} + {1'b0, lock_width};
    old_b   = {2'b00, lock_top}  + {1'b0, lock_height};
    ext_w   = (({1'b0, new_r} > old_r) ? {1'b0, new_r} : old_r) - {2'b00, merge_l};
    ext_h   = (({1'b0, new_b} > old_b) ? {1'b0, new_b} : old_b) - {2'b00, merge_t};
  end

  // Command sequencer: next state and actions.
  always_comb begin
    cursor_present_next = cursor_present;
    cursor_hidden_next  = cursor_hidden;
    lock_active_next    = lock_active;
    cursor_x_next       = cursor_x;
    cursor_y_next       = cursor_y;
    hotspot_x_next      = hotspot_x;
    hotspot_y_next      = hotspot_y;
    cursor_w_next       = cursor_w;
    cursor_h_next       = cursor_h;
    lock_left_next      = lock_left;
    lock_top_next       = lock_top;
    lock_width_next     = lock_width;
    lock_height_next    = lock_height;
    seq_state_next      = seq_state;
    second_next         = second;
    pop                 = 1'b0;
    emit                = 1'b0;
    emit_action         = ACT_RESTORE;
    emit_last           = 1'b1;

    case (seq_state)
      SEQ_FIRST: begin
        if (!empty && advance) begin
          pop = 1'b1;
          case (head.op)
            OP_SHAPE: begin
              if (cursor_present) begin
                emit        = 1'b1;
                emit_action = ACT_RESTORE;
                emit_last   = !shape_nonzero;
              end
              cursor_present_next = 1'b0;
              if (shape_nonzero) begin
                hotspot_x_next      = head.hx;
                hotspot_y_next      = head.hy;
                cursor_w_next       = head.sw;
                cursor_h_next       = head.sh;
                cursor_present_next = 1'b1;
                cursor_hidden_next  = 1'b0;
                lock_active_next    = 1'b0;
                seq_state_next      = SEQ_SECOND;
                second_next         = SEC_DRAW;
              end
            end
            OP_MOVE: begin
              if (cursor_present && !cursor_hidden) begin
                emit               = 1'b1;
                emit_action        = ACT_RESTORE;
                emit_last          = !draw_follow;
                cursor_hidden_next = 1'b1;
              end
              cursor_x_next = head.px;
              cursor_y_next = head.py;
              if (draw_follow) begin
                seq_state_next = SEQ_SECOND;
                second_next    = SEC_DRAW;
              end
            end
            OP_LOCK: begin
              if (cursor_present) begin
                if (!lock_active) begin
                  lock_left_next   = head.px;
                  lock_top_next    = head.py;
                  lock_width_next  = {1'b0, head.lw};
                  lock_height_next = {1'b0, head.lh};
                  lock_active_next = 1'b1;
                end else begin
                  lock_left_next   = merge_l;
                  lock_top_next    = merge_t;
                  lock_width_next  = ext_w[LOCK_EXT_W-1:0];
                  lock_height_next = ext_h[LOCK_EXT_W-1:0];
                end
                seq_state_next = SEQ_SECOND;
                second_next    = SEC_CHECK;
              end
            end
            OP_UNLOCK: begin
              if (cursor_present) begin
                if (cursor_hidden) begin
                  emit        = 1'b1;
                  emit_action = ACT_DRAW;
                  emit_last   = 1'b1;
                end
                cursor_hidden_next = 1'b0;
                lock_active_next   = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      SEQ_SECOND: begin
        if (advance) begin
          seq_state_next = SEQ_FIRST;
          case (second)
            SEC_DRAW: begin
              emit               = 1'b1;
              emit_action        = ACT_DRAW;
              emit_last          = 1'b1;
              cursor_hidden_next = 1'b0;
            end
            SEC_CHECK: begin
              if (!cursor_hidden && locked_cur) begin
                emit               = 1'b1;
                emit_action        = ACT_RESTORE;
                emit_last          = 1'b1;
                cursor_hidden_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        seq_state_next = SEQ_FIRST;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_present <= 1'b0;
      cursor_hidden  <= 1'b0;
      lock_active    <= 1'b0;
      cursor_x       <= '0;
      cursor_y       <= '0;
      hotspot_x      <= '0;
      hotspot_y      <= '0;
      cursor_w       <= '0;
      cursor_h       <= '0;
      lock_left      <= '0;
      lock_top       <= '0;
      lock_width     <= '0;
      lock_height    <= '0;
      seq_state      <= SEQ_FIRST;
      second         <= SEC_DRAW;
    end else begin
      cursor_present <= cursor_present_next;
      cursor_hidden  <= cursor_hidden_next;
      lock_active    <= lock_active_next;
      cursor_x       <= cursor_x_next;
      cursor_y       <= cursor_y_next;
      hotspot_x      <= hotspot_x_next;
      hotspot_y      <= hotspot_y_next;
      cursor_w       <= cursor_w_next;
      cursor_h       <= cursor_h_next;
      lock_left      <= lock_left_next;
      lock_top       <= lock_top_next;
      lock_width     <= lock_width_next;
      lock_height    <= lock_height_next;
      seq_state      <= seq_state_next;
      second         <= second_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (emit) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  // Result payload; an area with nothing on screen reads as all zeros.
  always_ff @(posedge clk) begin
    if (emit) begin
      result.action    <= emit_action;
      result.last      <= emit_last;
      result.on_screen <= clip_on;
      if (clip_on) begin
        result.area_x <= clip_l[COORD_W-1:0];
        result.area_y <= clip_t[COORD_W-1:0];
        result.area_w <= span_w[SIZE_W-1:0];
        result.area_h <= span_h[SIZE_W-1:0];
      end else begin
        result.area_x <= '0;
        result.area_y <= '0;
        result.area_w <= '0;
        result.area_h <= '0;
      end
    end
  end

  // Every action concerns a cursor that exists.
  a_emit_present: assert property (@(posedge clk) disable iff (rst)
    emit |-> cursor_present)
    else $error("action issued with no cursor present");

  // After a draw the cursor is visible.
  a_draw_shows: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_action == ACT_DRAW) |=> !cursor_hidden)
    else $error("cursor still hidden after a draw");

  // An action that is not the last one is always followed by a second step.
  a_not_last_second: assert property (@(posedge clk) disable iff (rst)
    (emit && !emit_last) |=> (seq_state == SEQ_SECOND))
    else $error("non-final action without a following step");

endmodule
